@@ src/ssmr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssmr_pkg
// Shared types and constants of the servo slow motion ramp block.
// ----------------------------------------------------------------------------
package ssmr_pkg;

	// field widths fixed by the interface
	localparam int PULSE_BITS_DEF = 12;
	localparam int ACTION_W       = 3;
	localparam int TIME_W         = 32;
	localparam int INTERVAL_W     = 16;
	localparam int STEP_W         = 8;
	localparam int CHAN_W         = 4;
	localparam int MOTION_W       = 2;
	localparam int CFG_IDX_W      = 3;

	// register reset values
	localparam int MIN_POS_RESET  = 205;
	localparam int MAX_POS_RESET  = 410;
	localparam int INTERVAL_RESET = 20;
	localparam int STEP_RESET     = 1;
	localparam int CHAN_RESET     = 0;

	// item commands
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK,
		ACT_MOVE_MIN,
		ACT_MOVE_MAX,
		ACT_JUMP_MIN,
		ACT_JUMP_MAX,
		ACT_JUMP_CENTRE
	} action_t;

	// servo motion state
	typedef enum logic [MOTION_W-1:0] {
		MOT_AT_MIN,
		MOT_AT_MAX,
		MOT_UP,
		MOT_DOWN
	} motion_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_POS,
		REG_MAX_POS,
		REG_INTERVAL,
		REG_STEP,
		REG_CHANNEL
	} cfg_reg_t;

	// fixed-width configuration fields
	typedef struct packed {
		logic [INTERVAL_W-1:0] step_interval;
		logic [STEP_W-1:0]     step_size;
		logic [CHAN_W-1:0]     channel;
	} cfg_t;

	// decisions taken for one item
	typedef struct packed {
		logic    wr;
		motion_t motion;
		logic    load_time;
		logic    load_pos;
	} step_ctrl_t;

endpackage

@@ src/ssmr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ssmr_cfg_regs
// Configuration register file: end positions, step interval, step size and
// expander channel, written through a plain write port.
// ----------------------------------------------------------------------------
module ssmr_cfg_regs import ssmr_pkg::*; #(
	parameter int PULSE_BITS = PULSE_BITS_DEF,
	parameter int CFG_W      = INTERVAL_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic [PULSE_BITS-1:0] min_pos,
	output logic [PULSE_BITS-1:0] max_pos,
	output cfg_t                  cfg
);

	logic [PULSE_BITS-1:0] min_pos_q;
	logic [PULSE_BITS-1:0] max_pos_q;
	cfg_t                  cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pos_q           <= PULSE_BITS'(MIN_POS_RESET);
			max_pos_q           <= PULSE_BITS'(MAX_POS_RESET);
			cfg_q.step_interval <= INTERVAL_W'(INTERVAL_RESET);
			cfg_q.step_size     <= STEP_W'(STEP_RESET);
			cfg_q.channel       <= CHAN_W'(CHAN_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_POS:  min_pos_q           <= cfg_data[PULSE_BITS-1:0];
				REG_MAX_POS:  max_pos_q           <= cfg_data[PULSE_BITS-1:0];
				REG_INTERVAL: cfg_q.step_interval <= cfg_data[INTERVAL_W-1:0];
				REG_STEP:     cfg_q.step_size     <= cfg_data[STEP_W-1:0];
				REG_CHANNEL:  cfg_q.channel       <= cfg_data[CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign min_pos = min_pos_q;
	assign max_pos = max_pos_q;
	assign cfg     = cfg_q;

endmodule

@@ src/ssmr_step.sv @@
// ----------------------------------------------------------------------------
// ssmr_step
// Per-item decision logic: ramp step with clamping, move start, jumps and
// centre value, from the current state and configuration.
// ----------------------------------------------------------------------------
module ssmr_step import ssmr_pkg::*; #(
	parameter int PULSE_BITS = PULSE_BITS_DEF
) (
	input  logic [ACTION_W-1:0]   action,
	input  logic [TIME_W-1:0]     now_ms,
	input  motion_t               motion,
	input  logic [PULSE_BITS-1:0] position,
	input  logic [TIME_W-1:0]     last_time,
	input  logic [PULSE_BITS-1:0] min_pos,
	input  logic [PULSE_BITS-1:0] max_pos,
	input  cfg_t                  cfg,
	output step_ctrl_t            ctrl,
	output logic [PULSE_BITS-1:0] pos_next,
	output logic [PULSE_BITS-1:0] value
);

	logic [TIME_W-1:0]   elapsed;
	logic                interval_done;
	logic                moving;
	logic [PULSE_BITS:0] step_ext;
	logic [PULSE_BITS:0] up_sum;
	logic [PULSE_BITS:0] dn_diff;
	logic                dn_clamp;
	logic [PULSE_BITS:0] ctr_sum;
	logic [PULSE_BITS-1:0] centre;

	// elapsed time modulo 2^32 against the step interval
	assign elapsed       = now_ms - last_time;
	assign interval_done = elapsed > {{(TIME_W-INTERVAL_W){1'b0}}, cfg.step_interval};
	assign moving        = (motion == MOT_UP) || (motion == MOT_DOWN);

	// wide up step and saturating down step
	assign step_ext = {{(PULSE_BITS+1-STEP_W){1'b0}}, cfg.step_size};
	assign up_sum   = {1'b0, position} + step_ext;
	assign dn_diff  = {1'b0, position} - step_ext;
	assign dn_clamp = dn_diff[PULSE_BITS] || (dn_diff[PULSE_BITS-1:0] < min_pos);

	// centre rounds toward the min end, also with inverted ends
	assign ctr_sum = {1'b0, min_pos} + {1'b0, max_pos} +
		{{PULSE_BITS{1'b0}}, (max_pos < min_pos)};
	assign centre  = ctr_sum[PULSE_BITS:1];

	// command decode
	always_comb begin
		ctrl.wr        = 1'b0;
		ctrl.motion    = motion;
		ctrl.load_time = 1'b0;
		ctrl.load_pos  = 1'b0;
		pos_next       = position;
		value          = '0;
		unique case (action_t'(action))
			ACT_TICK: begin
				if (moving && interval_done) begin
					ctrl.wr        = 1'b1;
					ctrl.load_time = 1'b1;
					ctrl.load_pos  = 1'b1;
					if (motion == MOT_UP) begin
						if (up_sum > {1'b0, max_pos}) begin
							pos_next    = max_pos;
							ctrl.motion = MOT_AT_MAX;
						end else begin
							pos_next = up_sum[PULSE_BITS-1:0];
						end
					end else begin
						if (dn_clamp) begin
							pos_next    = min_pos;
							ctrl.motion = MOT_AT_MIN;
						end else begin
							pos_next = dn_diff[PULSE_BITS-1:0];
						end
					end
					value = pos_next;
				end
			end
			ACT_MOVE_MIN: begin
				if (motion != MOT_AT_MIN) begin
					ctrl.load_time = 1'b1;
					ctrl.load_pos  = 1'b1;
					ctrl.motion    = MOT_DOWN;
					pos_next       = max_pos;
				end
			end
			ACT_MOVE_MAX: begin
				if (motion != MOT_AT_MAX) begin
					ctrl.load_time = 1'b1;
					ctrl.load_pos  = 1'b1;
					ctrl.motion    = MOT_UP;
					pos_next       = min_pos;
				end
			end
			ACT_JUMP_MIN: begin
				ctrl.wr     = 1'b1;
				ctrl.motion = MOT_AT_MIN;
				value       = min_pos;
			end
			ACT_JUMP_MAX: begin
				ctrl.wr     = 1'b1;
				ctrl.motion = MOT_AT_MAX;
				value       = max_pos;
			end
			ACT_JUMP_CENTRE: begin
				ctrl.wr = 1'b1;
				value   = centre;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/servo_slow_motion_ramp.sv @@
// ----------------------------------------------------------------------------
// servo_slow_motion_ramp
// Pipeline: an accepted item passes through the input register and then the
//   result register; one result per item.
// Throughput: one item per cycle while results are taken (out_ready); the step
//   logic between the input register and the result register is combinational.
// Reset: asynchronous, active low; servo rests at minimum, position takes the
//   min_position reset value, last step time is zero, registers take defaults.
// ----------------------------------------------------------------------------
module servo_slow_motion_ramp import ssmr_pkg::*; #(
	parameter int PULSE_BITS = PULSE_BITS_DEF,
	localparam int CFG_W = (PULSE_BITS > INTERVAL_W) ? PULSE_BITS : INTERVAL_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// items in
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ACTION_W-1:0]   action,
	input  logic [TIME_W-1:0]     now_ms,
	// results out
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  write_valid,
	output logic [CHAN_W-1:0]     channel,
	output logic [PULSE_BITS-1:0] pulse_value,
	output logic [MOTION_W-1:0]   motion_state
);

	logic [PULSE_BITS-1:0] min_pos;
	logic [PULSE_BITS-1:0] max_pos;
	cfg_t                  cfg;

	logic                  valid_s1;
	logic [ACTION_W-1:0]   action_s1;
	logic [TIME_W-1:0]     now_s1;

	motion_t               motion_q;
	logic [PULSE_BITS-1:0] position_q;
	logic [TIME_W-1:0]     last_time_q;

	step_ctrl_t            ctrl;
	logic [PULSE_BITS-1:0] pos_next;
	logic [PULSE_BITS-1:0] value;

	logic                  valid_s2;
	logic                  wr_s2;
	logic [CHAN_W-1:0]     chan_s2;
	logic [PULSE_BITS-1:0] value_s2;
	motion_t               motion_s2;

	logic                  advance;

	ssmr_cfg_regs #(
		.PULSE_BITS (PULSE_BITS),
		.CFG_W      (CFG_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.min_pos   (min_pos),
		.max_pos   (max_pos),
		.cfg       (cfg)
	);

	ssmr_step #(
		.PULSE_BITS (PULSE_BITS)
	) u_step (
		.action    (action_s1),
		.now_ms    (now_s1),
		.motion    (motion_q),
		.position  (position_q),
		.last_time (last_time_q),
		.min_pos   (min_pos),
		.max_pos   (max_pos),
		.cfg       (cfg),
		.ctrl      (ctrl),
		.pos_next  (pos_next),
		.value     (value)
	);

	// flow control: stage 1 moves on when the result register is free
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			now_s1    <= now_ms;
		end
	end

	// servo state, updated as an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q    <= MOT_AT_MIN;
			position_q  <= PULSE_BITS'(MIN_POS_RESET);
			last_time_q <= '0;
		end else if (advance) begin
			motion_q <= ctrl.motion;
			if (ctrl.load_pos) begin
				position_q <= pos_next;
			end
			if (ctrl.load_time) begin
				last_time_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_s2     <= ctrl.wr;
			chan_s2   <= cfg.channel;
			value_s2  <= value;
			motion_s2 <= ctrl.motion;
		end
	end

	assign out_valid    = valid_s2;
	assign write_valid  = wr_s2;
	assign channel      = chan_s2;
	assign pulse_value  = value_s2;
	assign motion_state = motion_s2;

	// a jump to min rests the servo at min and writes
	a_jump_min: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (action_s1 == ACT_JUMP_MIN) |=>
			(motion_q == MOT_AT_MIN) && wr_s2 && (value_s2 == $past(min_pos)))
		else $error("jump to min did not rest at min");

	// a result without a write carries a zero pulse value
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> (pulse_value == '0))
		else $error("pulse value not zero without write");

	// a move to max from anywhere but max starts an upward ramp at min
	a_move_up: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (action_s1 == ACT_MOVE_MAX) && (motion_q != MOT_AT_MAX) |=>
			(motion_q == MOT_UP) && (position_q == $past(min_pos)) && !wr_s2)
		else $error("move to max did not start ramp");

	// the result register holds while stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(value_s2) && $stable(motion_s2))
		else $error("stalled result changed");

endmodule

@@ verif/servo_slow_motion_ramp_test.sv @@
// ----------------------------------------------------------------------------
// servo_slow_motion_ramp_test
// Self-checking bench for the servo ramp block. Commands and ticks go in
// through a valid/ready driver with random gaps, and results come back through
// a monitor with random stalls. A behavioral servo model predicts every
// result, and the monitor checks each one field by field. The end positions,
// interval, step size and channel are reloaded between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module servo_slow_motion_ramp_test;
	import ssmr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_BITS       = (PULSE_BITS_DEF > INTERVAL_W) ? PULSE_BITS_DEF : INTERVAL_W;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 150;
	localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

	// one command item as queued for the driver
	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [TIME_W-1:0]   stamp;
		int                  gap;
	} servo_cmd_t;

	// one predicted result
	typedef struct packed {
		logic                      wr;
		logic [CHAN_W-1:0]         chan;
		logic [PULSE_BITS_DEF-1:0] value;
		motion_t                   motion;
	} servo_write_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_BITS-1:0]       cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [ACTION_W-1:0]       action;
	logic [TIME_W-1:0]         now_ms;
	logic                      out_valid;
	logic                      out_ready;
	logic                      write_valid;
	logic [CHAN_W-1:0]         channel;
	logic [PULSE_BITS_DEF-1:0] pulse_value;
	logic [MOTION_W-1:0]       motion_state;

	// servo model: registers
	logic [PULSE_BITS_DEF-1:0] end_min;
	logic [PULSE_BITS_DEF-1:0] end_max;
	logic [INTERVAL_W-1:0]     interval_ms;
	logic [STEP_W-1:0]         step_units;
	logic [CHAN_W-1:0]         chan_sel;

	// servo model: state
	motion_t                   srv_motion;
	logic [PULSE_BITS_DEF-1:0] srv_pos;
	logic [TIME_W-1:0]         srv_last;

	servo_cmd_t   servo_cmds[$];
	servo_write_t pulse_writes_due[$];
	servo_cmd_t   send_item;
	bit           send_loaded;
	bit           send_active;
	int           send_gap;
	int           ready_gap;
	bit           quiet;
	int           error_count;
	int           stall_cycles;
	logic [TIME_W-1:0] clock_ms;

	servo_slow_motion_ramp DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.write_valid(write_valid),
		.channel(channel),
		.pulse_value(pulse_value),
		.motion_state(motion_state)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// idle cycles before an item or after a result
	function automatic int draw_gap();
		if (quiet || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	function automatic void reset_model();
		end_min     = PULSE_BITS_DEF'(MIN_POS_RESET);
		end_max     = PULSE_BITS_DEF'(MAX_POS_RESET);
		interval_ms = INTERVAL_W'(INTERVAL_RESET);
		step_units  = STEP_W'(STEP_RESET);
		chan_sel    = CHAN_W'(CHAN_RESET);
		srv_motion  = MOT_AT_MIN;
		srv_pos     = end_min;
		srv_last    = '0;
	endfunction

	// next servo state and written value for one command
	function automatic servo_write_t servo_update(input logic [ACTION_W-1:0] act,
			input logic [TIME_W-1:0] stamp);
		servo_write_t res;
		logic [TIME_W-1:0] elapsed;
		logic [PULSE_BITS_DEF:0] sum;
		res.wr    = 1'b0;
		res.value = '0;
		elapsed   = stamp - srv_last;
		case (act)
			ACT_TICK: begin
				if ((srv_motion == MOT_UP || srv_motion == MOT_DOWN) &&
						elapsed > TIME_W'(interval_ms)) begin
					srv_last = stamp;
					if (srv_motion == MOT_UP) begin
						// upward step formed one bit wider, clamped at the top end
						sum = {1'b0, srv_pos} + step_units;
						if (sum > {1'b0, end_max}) begin
							srv_pos    = end_max;
							srv_motion = MOT_AT_MAX;
						end else begin
							srv_pos = sum[PULSE_BITS_DEF-1:0];
						end
					end else begin
						// downward step saturates at the bottom end
						if (srv_pos < step_units || srv_pos - step_units < end_min) begin
							srv_pos    = end_min;
							srv_motion = MOT_AT_MIN;
						end else begin
							srv_pos = srv_pos - step_units;
						end
					end
					res.wr    = 1'b1;
					res.value = srv_pos;
				end
			end
			ACT_MOVE_MIN: begin
				if (srv_motion != MOT_AT_MIN) begin
					srv_last   = stamp;
					srv_pos    = end_max;
					srv_motion = MOT_DOWN;
				end
			end
			ACT_MOVE_MAX: begin
				if (srv_motion != MOT_AT_MAX) begin
					srv_last   = stamp;
					srv_pos    = end_min;
					srv_motion = MOT_UP;
				end
			end
			ACT_JUMP_MIN: begin
				res.wr     = 1'b1;
				res.value  = end_min;
				srv_motion = MOT_AT_MIN;
			end
			ACT_JUMP_MAX: begin
				res.wr     = 1'b1;
				res.value  = end_max;
				srv_motion = MOT_AT_MAX;
			end
			ACT_JUMP_CENTRE: begin
				// halfway, rounded toward the min end even when the ends are swapped
				res.wr = 1'b1;
				if (end_max >= end_min)
					res.value = end_min + (end_max - end_min) / 2;
				else
					res.value = end_min - (end_min - end_max) / 2;
			end
			default: begin
			end
		endcase
		res.chan   = chan_sel;
		res.motion = srv_motion;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// register write, mirrored into the model
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_POS:  end_min     = val[PULSE_BITS_DEF-1:0];
			REG_MAX_POS:  end_max     = val[PULSE_BITS_DEF-1:0];
			REG_INTERVAL: interval_ms = val[INTERVAL_W-1:0];
			REG_STEP:     step_units  = val[STEP_W-1:0];
			REG_CHANNEL:  chan_sel    = val[CHAN_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic load_setup(input int lo, input int hi, input int gap_ms, input int step,
			input int chan);
		write_reg(REG_MIN_POS, CFG_BITS'(lo));
		write_reg(REG_MAX_POS, CFG_BITS'(hi));
		write_reg(REG_INTERVAL, CFG_BITS'(gap_ms));
		write_reg(REG_STEP, CFG_BITS'(step));
		write_reg(REG_CHANNEL, CFG_BITS'(chan));
		@(posedge clk);
	endtask

	task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] stamp);
		servo_cmd_t cmd;
		cmd.act   = act;
		cmd.stamp = stamp;
		cmd.gap   = draw_gap();
		servo_cmds.push_back(cmd);
	endtask

	// mostly ramps driven by ticks past the interval, with some noise
	task automatic queue_random_item();
		int r;
		int pick;
		logic [ACTION_W-1:0] act;
		r = $urandom_range(0, 99);
		if (r < 67) begin
			act  = ACT_TICK;
			pick = $urandom_range(0, 9);
			if (pick < 7)
				clock_ms += TIME_W'(interval_ms) + 1 + $urandom_range(0, 3);
			else if (pick < 9)
				clock_ms += $urandom_range(0, interval_ms);
			else
				clock_ms = $urandom();
		end else if (r < 87) begin
			act = $urandom_range(0, 1) ? ACT_MOVE_MIN : ACT_MOVE_MAX;
			clock_ms += $urandom_range(0, 5);
		end else if (r < 97) begin
			pick = $urandom_range(0, 2);
			act = (pick == 0) ? ACT_JUMP_MIN : (pick == 1) ? ACT_JUMP_MAX : ACT_JUMP_CENTRE;
			clock_ms += $urandom_range(0, 5);
		end else begin
			act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
			clock_ms += $urandom_range(0, 5);
		end
		queue_item(act, clock_ms);
	endtask

	// wait until every item is sent and every result is back
	task automatic settle();
		while (servo_cmds.size() != 0 || send_loaded || send_active ||
				pulse_writes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// item driver
	always @(negedge clk) begin
		if (arst_n && !send_active) begin
			if (!send_loaded && servo_cmds.size() != 0) begin
				send_item   = servo_cmds.pop_front();
				send_gap    = send_item.gap;
				send_loaded = 1'b1;
			end
			if (send_loaded && send_gap == 0) begin
				in_valid    <= 1'b1;
				action      <= send_item.act;
				now_ms      <= send_item.stamp;
				send_active = 1'b1;
				send_loaded = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (send_loaded)
					send_gap--;
			end
		end
	end

	// result stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_gap > 0) begin
				out_ready <= 1'b0;
				ready_gap--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// prediction on accepted items, checking of accepted results, watchdog
	always @(posedge clk) begin
		servo_write_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pulse_writes_due.push_back(servo_update(action, now_ms));
				send_active = 1'b0;
			end
			if (out_valid && out_ready) begin
				ready_gap = draw_gap();
				if (pulse_writes_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual write_valid %0b value %0d",
						$time, write_valid, pulse_value);
					error_count++;
				end else begin
					want = pulse_writes_due.pop_front();
					check_field("write_valid", want.wr, write_valid);
					check_field("channel", want.chan, channel);
					check_field("pulse_value", want.value, pulse_value);
					check_field("motion_state", want.motion, motion_state);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no item moved for %0d cycles", $time, stall_cycles);
					$display("servo_slow_motion_ramp_test failed");
					$finish;
				end
			end
		end
	end

	// stimulus
	initial begin
		int lo;
		int hi;
		int gap_ms;
		int step;
		int pick;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_MIN_POS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		action      = ACT_TICK;
		now_ms      = '0;
		out_ready   = 1'b0;
		send_loaded = 1'b0;
		send_active = 1'b0;
		send_gap    = 0;
		ready_gap   = 0;
		quiet       = 1'b0;
		error_count = 0;
		stall_cycles = 0;
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: rest, interval edge, time wrap, spare codes, jumps
		queue_item(ACT_TICK, 32'd50);
		queue_item(ACT_MOVE_MIN, 32'd60);
		queue_item(ACT_MOVE_MAX, 32'd100);
		queue_item(ACT_TICK, 32'd120);
		queue_item(ACT_TICK, 32'd121);
		queue_item(ACT_JUMP_CENTRE, 32'd130);
		queue_item(ACT_SPARE_A, 32'd140);
		queue_item(ACT_SPARE_B, 32'd150);
		queue_item(ACT_MOVE_MAX, 32'd160);
		queue_item(ACT_MOVE_MIN, 32'hFFFF_FFF0);
		queue_item(ACT_TICK, 32'h0000_0005);
		queue_item(ACT_JUMP_MAX, 32'd6);
		queue_item(ACT_MOVE_MAX, 32'd7);
		queue_item(ACT_JUMP_MIN, 32'd8);
		settle();

		// swapped ends, largest step, zero interval
		load_setup(4095, 0, 0, 255, 15);
		queue_item(ACT_JUMP_CENTRE, 32'd1);
		queue_item(ACT_MOVE_MAX, 32'd2);
		queue_item(ACT_TICK, 32'd2);
		queue_item(ACT_TICK, 32'd3);
		queue_item(ACT_MOVE_MIN, 32'd4);
		queue_item(ACT_TICK, 32'd5);
		settle();

		// zero step, longest interval
		load_setup(0, 4095, 65535, 0, 5);
		queue_item(ACT_MOVE_MAX, 32'h8000_0000);
		queue_item(ACT_TICK, 32'h8000_FFFF);
		queue_item(ACT_TICK, 32'h8001_0000);
		queue_item(ACT_JUMP_MAX, 32'h8001_0001);
		queue_item(ACT_MOVE_MIN, 32'h8001_0002);
		queue_item(ACT_TICK, 32'h8002_0003);
		settle();

		// random phases, each with its own setup
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				lo = 0; hi = 4095; gap_ms = 0; step = 255;
			end else if (p == 1) begin
				lo = 4000; hi = 4095; gap_ms = 65535; step = 1;
			end else begin
				lo = $urandom_range(0, 4095);
				hi = lo + $urandom_range(0, 400);
				if (hi > 4095)
					hi = 4095;
				if ($urandom_range(0, 5) == 0) begin
					pick = lo; lo = hi; hi = pick;
				end
				pick = $urandom_range(0, 5);
				gap_ms = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 40);
				pick = $urandom_range(0, 7);
				step = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(1, 8) : $urandom_range(1, 255);
			end
			load_setup(lo, hi, gap_ms, step, $urandom_range(0, 15));
			quiet = ($urandom_range(0, 3) == 0);
			clock_ms = $urandom();
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_random_item();
			settle();
		end

		if (error_count == 0)
			$display("servo_slow_motion_ramp_test passed");
		else
			$display("servo_slow_motion_ramp_test failed");
		$finish;
	end

endmodule
